// ===== rtl/ppad_pkg.sv =====
// Package for the pixel pair averaging downscaler.
// Holds the payload types, register indexes and sizing constants.
// No dependencies.
`default_nettype none

package ppad_pkg;

    // Default and widest line length in pixels.
    localparam int PPAD_MAX_LINE = 4096;

    // Widths of the configuration registers.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 13;
    localparam int LINE_W_BITS    = 13;
    localparam int COUNT_BITS     = 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HALVE_HEIGHT    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COMPONENT_COUNT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LINE_WIDTH      = 2'd2;

    // Register values after reset.
    localparam logic [COUNT_BITS-1:0]  RST_COMPONENT_COUNT = 3'd4;
    localparam logic [LINE_W_BITS-1:0] RST_LINE_WIDTH      = 13'd4096;

    // Four component bytes of one pixel, component 0 in the low byte.
    typedef logic [3:0][7:0] t_pixel;

    // One input beat.
    typedef struct packed {
        logic [7:0] component_0;
        logic [7:0] component_1;
        logic [7:0] component_2;
        logic [7:0] component_3;
        logic       last_pixel;
    } t_pix_in;

    // One output beat.
    typedef struct packed {
        logic [7:0] average_0;
        logic [7:0] average_1;
        logic [7:0] average_2;
        logic [7:0] average_3;
        logic       row_end;
        logic       image_end;
    } t_pix_out;

endpackage

`default_nettype wire

// ===== rtl/pixel_pair_average_downscale.sv =====
// Top level of the 2:1 pixel pair averaging downscaler.
// Depends on ppad_pkg, ppad_ram and ppad_avg.
//
// Input pixels arrive in raster order on i_valid / o_stall with payload
// i_data; averaged pixels leave on o_valid / i_stall with payload o_data.
// A beat moves on an edge where valid is high and stall is low.
// Width mode emits one beat per odd column from the held even pixel; height
// mode writes even rows into a line buffer and averages each odd-row pixel
// with the one stored above it.
// A result is registered in the pipeline register, while the line buffer
// read happens alongside it, and then in the output register.
// Throughput: one input beat per cycle while the output is not stalled, set
// by the line buffer ports and the two-register pipeline; pixels without a
// result just update the column state.
// The configuration port (i_cfg_valid / o_cfg_ready) is always ready; the
// user must write it only while idle; the block itself does not enforce it.
// Reset clears the column counter, the row phase, the pipeline and sets the
// registers to width mode, four components and a 4096 pixel line. The line
// buffer is not cleared; every entry is written before it is read.
// While the receiver stalls, the output holds, and the input stalls as soon
// as the pipeline register behind the output is also full.
`default_nettype none

module pixel_pair_average_downscale
    import ppad_pkg::*;
#(
    parameter int MAX_LINE = PPAD_MAX_LINE
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire t_pix_in                   i_data,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output t_pix_out                       o_data,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int COL_W = (MAX_LINE > 2) ? $clog2(MAX_LINE) : 1;
    localparam int MAX_BITS = $clog2(MAX_LINE + 1);
    localparam int EW = (LINE_W_BITS > MAX_BITS) ? LINE_W_BITS : MAX_BITS;

    // Configuration registers.
    logic                   r_halve_height;
    logic [COUNT_BITS-1:0]  r_component_count;
    logic [LINE_W_BITS-1:0] r_line_width;

    // Raster position and pending pixel.
    logic [COL_W-1:0] r_col, n_col;
    logic             r_odd_row, n_odd_row;
    t_pixel           r_held;

    // Pipeline register between input and output.
    logic       r_s1_valid;
    logic       r_s1_use_ram;
    t_pixel     r_s1_a;
    t_pixel     r_s1_b;
    logic       r_s1_row_end;
    logic       r_s1_image_end;

    // Output register.
    logic       r_s2_valid;
    t_pix_out   r_s2_data;

    logic       in_accept;
    logic       s2_load;
    logic       emit;
    logic       at_row_end;
    logic       ram_we;
    logic       ram_re;
    t_pixel     pix;
    t_pixel     ram_rdata;
    t_pixel     avg_a;
    t_pixel     avg;
    logic [EW-1:0] lw_ext;
    logic [EW-1:0] eff_w;
    logic [EW-1:0] w_m1;

    assign pix = {i_data.component_3, i_data.component_2,
                  i_data.component_1, i_data.component_0};

    // Handshakes.
    assign o_cfg_ready = 1'b1;
    assign s2_load     = !r_s2_valid || !i_stall;
    assign o_stall     = r_s1_valid && !s2_load;
    assign in_accept   = i_valid && !o_stall;
    assign o_valid     = r_s2_valid;
    assign o_data      = r_s2_data;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halve_height    <= 1'b0;
            r_component_count <= RST_COMPONENT_COUNT;
            r_line_width      <= RST_LINE_WIDTH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_HALVE_HEIGHT:    r_halve_height    <= i_cfg_data[0];
                CFG_COMPONENT_COUNT: r_component_count <= i_cfg_data[COUNT_BITS-1:0];
                CFG_LINE_WIDTH:      r_line_width      <= i_cfg_data[LINE_W_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Effective line width: clamped to 2..MAX_LINE and made even.
    always_comb begin
        lw_ext = EW'(r_line_width);
        if (lw_ext < EW'(2)) begin
            eff_w = EW'(2);
        end else if (lw_ext > EW'(MAX_LINE)) begin
            eff_w = EW'(MAX_LINE);
        end else begin
            eff_w = lw_ext;
        end
        eff_w[0] = 1'b0;
        w_m1 = eff_w - EW'(1);
    end

    assign at_row_end = EW'(r_col) >= w_m1;

    // A result follows odd columns in width mode and odd rows in height mode.
    assign emit   = r_halve_height ? r_odd_row : r_col[0];
    assign ram_we = in_accept && r_halve_height && !r_odd_row;
    assign ram_re = in_accept && r_halve_height && r_odd_row;

    // Next raster position.
    always_comb begin
        n_col     = r_col;
        n_odd_row = r_odd_row;
        if (i_data.last_pixel) begin
            n_col     = '0;
            n_odd_row = 1'b0;
        end else if (at_row_end) begin
            n_col     = '0;
            n_odd_row = !r_odd_row;
        end else begin
            n_col = r_col + COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_odd_row <= 1'b0;
            r_held    <= '0;
        end else if (in_accept) begin
            r_col     <= n_col;
            r_odd_row <= n_odd_row;
            if (!r_halve_height && !r_col[0]) begin
                r_held <= pix;
            end
        end
    end

    // Line buffer holding the even row.
    ppad_ram #(
        .WIDTH ($bits(t_pixel)),
        .DEPTH (MAX_LINE)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_col),
        .i_wdata (pix),
        .i_re    (ram_re),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // Pipeline register: operands and end marks of a beat that gives a result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= emit;
        end else if (s2_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_use_ram   <= r_halve_height;
            r_s1_a         <= r_held;
            r_s1_b         <= pix;
            r_s1_row_end   <= at_row_end || i_data.last_pixel;
            r_s1_image_end <= i_data.last_pixel;
        end
    end

    // Averaging of the pair.
    assign avg_a = r_s1_use_ram ? ram_rdata : r_s1_a;

    ppad_avg u_avg (
        .i_a     (avg_a),
        .i_b     (r_s1_b),
        .i_count (r_component_count),
        .o_avg   (avg)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_load) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load && r_s1_valid) begin
            r_s2_data.average_0 <= avg[0];
            r_s2_data.average_1 <= avg[1];
            r_s2_data.average_2 <= avg[2];
            r_s2_data.average_3 <= avg[3];
            r_s2_data.row_end   <= r_s1_row_end;
            r_s2_data.image_end <= r_s1_image_end;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ppad_ram.sv =====
// Generic simple dual port RAM with a registered, enabled read.
// Used for the line buffer. No dependencies.
`default_nettype none

module ppad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ppad_avg.sv =====
// Per-component floor average of two pixels with unused components zeroed.
// Depends on ppad_pkg.
`default_nettype none

module ppad_avg
    import ppad_pkg::*;
(
    input  wire t_pixel                i_a,
    input  wire t_pixel                i_b,
    input  wire logic [COUNT_BITS-1:0] i_count,
    output t_pixel                     o_avg
);

    logic [COUNT_BITS-1:0] eff_count;
    logic [8:0]            sum [4];

    // Out-of-range counts: zero acts as one, above four acts as four.
    always_comb begin
        if (i_count == '0) begin
            eff_count = COUNT_BITS'(1);
        end else if (i_count > COUNT_BITS'(4)) begin
            eff_count = COUNT_BITS'(4);
        end else begin
            eff_count = i_count;
        end
    end

    // Nine-bit sum per component, halved by dropping the low bit.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            sum[k] = {1'b0, i_a[k]} + {1'b0, i_b[k]};
            if (COUNT_BITS'(k) < eff_count) begin
                o_avg[k] = sum[k][8:1];
            end else begin
                o_avg[k] = 8'd0;
            end
        end
    end

endmodule

`default_nettype wire
